>>> rtl/tpbp_pkg.sv
// ----------------------------------------------------------------------------
// tpbp_pkg
// Shared types, constants and helpers of the text to pixel bit packer.
// ----------------------------------------------------------------------------
package tpbp_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int DIM_W       = 12;
    localparam int COL_W       = 11;
    localparam int ROW_W       = 12;
    localparam int ACC_W       = 31;
    localparam int PEND_W      = 5;
    localparam int CHAN_W      = 8;
    localparam int NBITS_W     = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int MAX_PIXELS  = 8;
    localparam int PIX_CNT_W   = $clog2(MAX_PIXELS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input operation codes
    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_FLUSH = 2'd1,
        OP_FILL  = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEFAULT_RED   = 3'd0,
        CFG_DEFAULT_GREEN = 3'd1,
        CFG_DEFAULT_BLUE  = 3'd2,
        CFG_RED_BITS      = 3'd3,
        CFG_GREEN_BITS    = 3'd4,
        CFG_BLUE_BITS     = 3'd5,
        CFG_WIDTH         = 3'd6,
        CFG_HEIGHT        = 3'd7
    } cfg_index_t;

    // Configuration as seen by the pixel engine: bit counts saturated,
    // dimensions clamped to 1..MAX
    typedef struct packed {
        logic [CHAN_W-1:0]  default_red;
        logic [CHAN_W-1:0]  default_green;
        logic [CHAN_W-1:0]  default_blue;
        logic [NBITS_W-1:0] red_bits;
        logic [NBITS_W-1:0] green_bits;
        logic [NBITS_W-1:0] blue_bits;
        logic [PEND_W-1:0]  total_bits;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } cfg_t;

    // Head of the command queue
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [CHAN_W-1:0] data;
    } queue_head_t;

    function automatic logic [NBITS_W-1:0] chan_sat(input logic [NBITS_W-1:0] b);
        return (b > NBITS_W'(8)) ? NBITS_W'(8) : b;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

>>> rtl/tpbp_front.sv
// ----------------------------------------------------------------------------
// tpbp_front
// Input side: accepts items, drops unknown operations and queues the rest
// for the pixel engine.
// ----------------------------------------------------------------------------
module tpbp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
    input  logic [1:0]                  s_axis_tuser,  // [1:0] operation
    output tpbp_pkg::queue_head_t       head,
    input  logic                        pop
);

    tpbp_pkg::op_t                    op_q_reg   [tpbp_pkg::QUEUE_DEPTH];
    logic [tpbp_pkg::CHAN_W-1:0]      data_q_reg [tpbp_pkg::QUEUE_DEPTH];
    logic [tpbp_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [tpbp_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [tpbp_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             known_op;
    logic                             push;
    logic                             do_pop;

    always_comb
    begin
        case (s_axis_tuser)
            tpbp_pkg::OP_DATA,
            tpbp_pkg::OP_FLUSH,
            tpbp_pkg::OP_FILL: known_op = 1'b1;
            default:           known_op = 1'b0;
        endcase
    end

    assign s_axis_tready = (count_reg != tpbp_pkg::QCNT_W'(tpbp_pkg::QUEUE_DEPTH));
    // unknown operations are taken and dropped here
    assign push   = s_axis_tvalid && s_axis_tready && known_op;
    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + tpbp_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + tpbp_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + tpbp_pkg::QCNT_W'(1);
        else if (!push && do_pop)
            count_next = count_reg - tpbp_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q_reg[wr_ptr_reg]   <= tpbp_pkg::op_t'(s_axis_tuser);
            data_q_reg[wr_ptr_reg] <= s_axis_tdata;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.op    = op_q_reg[rd_ptr_reg];
    assign head.data  = data_q_reg[rd_ptr_reg];

endmodule

>>> rtl/tpbp_back.sv
// ----------------------------------------------------------------------------
// tpbp_back
// Pixel engine: appends text bytes to the bit accumulator, cuts pixels out
// of it, tracks the picture position and drives the output register.
// ----------------------------------------------------------------------------
module tpbp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpbp_pkg::cfg_t              cfg,
    input  tpbp_pkg::queue_head_t       head,
    output logic                        pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] blue_value, [15:8] green_value, [23:16] red_value,
    // [34:24] pixel_column, [45:35] stored_row, [47:46] zero
    output logic [47:0]                 m_axis_tdata,
    output logic                        m_axis_tlast,  // last_of_run
    // [0] picture_complete, [1] overflow_error
    output logic [1:0]                  m_axis_tuser
);

    logic [tpbp_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [tpbp_pkg::PEND_W-1:0]    pend_reg, pend_next;
    logic [tpbp_pkg::COL_W-1:0]     col_reg, col_next;
    logic [tpbp_pkg::ROW_W-1:0]     row_reg, row_next;
    logic                           busy_reg, busy_next;
    logic [tpbp_pkg::PIX_CNT_W-1:0] cnt_reg, cnt_next;

    logic                         out_valid_reg, out_valid_next;
    logic [tpbp_pkg::CHAN_W-1:0]  out_blue_reg, out_green_reg, out_red_reg;
    logic [tpbp_pkg::COL_W-1:0]   out_col_reg;
    logic [tpbp_pkg::COL_W-1:0]   out_row_reg;
    logic                         out_last_reg, out_cpl_reg, out_ovf_reg;

    logic                         out_ok;
    logic                         start;
    logic                         need;
    logic                         force_ovf;
    logic                         use_data;
    logic                         data_path;
    logic                         flush_clear;
    logic                         emit;
    logic                         more;
    logic                         ovf;
    logic [31:0]                  shifted_byte;
    logic [tpbp_pkg::ACC_W-1:0]   app_acc;
    logic [tpbp_pkg::PEND_W:0]    app_sum;
    logic [tpbp_pkg::PEND_W-1:0]  app_pend;
    logic [tpbp_pkg::ACC_W-1:0]   work_acc;
    logic [tpbp_pkg::PEND_W-1:0]  work_pend;
    logic [tpbp_pkg::PEND_W-1:0]  pend_after;
    logic [tpbp_pkg::ACC_W-1:0]   sh_green, sh_red, rest;
    logic [tpbp_pkg::CHAN_W-1:0]  db, dg, dr;
    logic [tpbp_pkg::PIX_CNT_W:0] cnt_plus;
    logic [tpbp_pkg::DIM_W-1:0]   col_inc;
    logic [tpbp_pkg::ROW_W-1:0]   row_inc;
    logic [tpbp_pkg::ROW_W-1:0]   row_after;
    logic [tpbp_pkg::DIM_W-1:0]   row_stored;

    function automatic logic [tpbp_pkg::CHAN_W-1:0] low_mask(
        input logic [tpbp_pkg::NBITS_W-1:0] n);
        logic [tpbp_pkg::CHAN_W:0] m;
        m = ((tpbp_pkg::CHAN_W+1)'(1) << n) - (tpbp_pkg::CHAN_W+1)'(1);
        return m[tpbp_pkg::CHAN_W-1:0];
    endfunction

    assign out_ok = !out_valid_reg || m_axis_tready;
    assign start  = head.valid && !busy_reg;

    // append the byte above the pending bits
    always_comb
    begin
        shifted_byte = 32'(head.data) << pend_reg;
        app_acc      = (pend_reg < tpbp_pkg::PEND_W'(31))
                     ? (acc_reg | shifted_byte[tpbp_pkg::ACC_W-1:0]) : acc_reg;
        app_sum      = {1'b0, pend_reg} + (tpbp_pkg::PEND_W+1)'(8);
        app_pend     = (app_sum > (tpbp_pkg::PEND_W+1)'(31))
                     ? tpbp_pkg::PEND_W'(31) : app_sum[tpbp_pkg::PEND_W-1:0];
    end

    // classify the work of this cycle
    always_comb
    begin
        need        = 1'b0;
        force_ovf   = 1'b0;
        use_data    = 1'b0;
        data_path   = 1'b0;
        flush_clear = 1'b0;
        work_acc    = acc_reg;
        work_pend   = pend_reg;
        if (busy_reg)
        begin
            need      = 1'b1;
            use_data  = 1'b1;
            data_path = 1'b1;
        end
        else if (head.valid)
        begin
            case (head.op)
                tpbp_pkg::OP_DATA:
                begin
                    if (cfg.total_bits == '0)
                    begin
                        need      = 1'b1;
                        force_ovf = 1'b1;
                    end
                    else
                    begin
                        work_acc  = app_acc;
                        work_pend = app_pend;
                        need      = (app_pend >= cfg.total_bits);
                        use_data  = 1'b1;
                        data_path = 1'b1;
                    end
                end
                tpbp_pkg::OP_FLUSH:
                begin
                    need        = (pend_reg != '0);
                    force_ovf   = (cfg.total_bits == '0);
                    use_data    = (cfg.total_bits != '0);
                    flush_clear = (pend_reg != '0);
                end
                tpbp_pkg::OP_FILL:
                begin
                    need = ({1'b0, row_reg} < {1'b0, cfg.height});
                end
                default:
                begin
                    need = 1'b0;
                end
            endcase
        end
    end

    assign emit = need && out_ok && (busy_reg || head.valid);
    assign pop  = start && (!need || out_ok);

    // cut the channel fields out of the working accumulator
    always_comb
    begin
        sh_green = work_acc >> cfg.blue_bits;
        sh_red   = work_acc >> (tpbp_pkg::PEND_W'(cfg.blue_bits)
                              + tpbp_pkg::PEND_W'(cfg.green_bits));
        rest     = work_acc >> cfg.total_bits;
        db       = use_data ? (work_acc[tpbp_pkg::CHAN_W-1:0] & low_mask(cfg.blue_bits)) : '0;
        dg       = use_data ? (sh_green[tpbp_pkg::CHAN_W-1:0] & low_mask(cfg.green_bits)) : '0;
        dr       = use_data ? (sh_red[tpbp_pkg::CHAN_W-1:0] & low_mask(cfg.red_bits)) : '0;
        pend_after = work_pend - cfg.total_bits;
        cnt_plus   = busy_reg ? ({1'b0, cnt_reg} + (tpbp_pkg::PIX_CNT_W+1)'(1))
                              : (tpbp_pkg::PIX_CNT_W+1)'(1);
        more       = emit && data_path && (pend_after >= cfg.total_bits)
                   && (cnt_plus < (tpbp_pkg::PIX_CNT_W+1)'(tpbp_pkg::MAX_PIXELS));
    end

    // picture position
    always_comb
    begin
        ovf        = force_ovf || ({1'b0, row_reg} >= {1'b0, cfg.height});
        col_inc    = {1'b0, col_reg} + tpbp_pkg::DIM_W'(1);
        row_inc    = row_reg + tpbp_pkg::ROW_W'(1);
        row_stored = cfg.height - tpbp_pkg::DIM_W'(1) - row_reg;
        if (col_inc >= cfg.width)
        begin
            col_next  = '0;
            row_after = row_inc;
        end
        else
        begin
            col_next  = col_inc[tpbp_pkg::COL_W-1:0];
            row_after = row_reg;
        end
        row_next = row_reg;
        if (!(emit && !ovf))
            col_next = col_reg;
        else
            row_next = row_after;
    end

    always_comb
    begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (emit || pop)
        begin
            if (data_path)
            begin
                acc_next  = emit ? rest : work_acc;
                pend_next = emit ? pend_after : work_pend;
            end
            else if (flush_clear)
            begin
                acc_next  = '0;
                pend_next = '0;
            end
            busy_next = more;
            cnt_next  = more ? cnt_plus[tpbp_pkg::PIX_CNT_W-1:0] : '0;
        end
        out_valid_next = emit ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pend_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_blue_reg  <= cfg.default_blue + db;
            out_green_reg <= cfg.default_green + dg;
            out_red_reg   <= cfg.default_red + dr;
            out_col_reg   <= ovf ? '0 : col_reg;
            out_row_reg   <= ovf ? '0 : row_stored[tpbp_pkg::COL_W-1:0];
            out_cpl_reg   <= ovf ? 1'b0 : ({1'b0, row_after} >= {1'b0, cfg.height});
            out_ovf_reg   <= ovf;
            out_last_reg  <= !more;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_row_reg, out_col_reg,
                            out_red_reg, out_green_reg, out_blue_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_cpl_reg};

`ifndef ASSERT_OFF
    a_busy_after_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("engine busy without a pixel emitted for the item");

    a_ovf_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ovf_reg) |->
            (out_col_reg == '0 && out_row_reg == '0 && !out_cpl_reg))
        else $error("overflow pixel carries a position");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.op == tpbp_pkg::OP_FLUSH) |=> pend_reg == '0)
        else $error("pending bits left after flush");

    a_ovf_holds_position: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && ovf) |=> ($stable(col_reg) && $stable(row_reg)))
        else $error("picture position moved on an overflow pixel");
`endif

endmodule

>>> rtl/text_to_pixel_bit_packer_unit.sv
// Text to pixel bit packer. Text bytes enter on the slave stream (operation in
// tuser: data byte, end-of-text flush, or fill one default pixel); pixels leave
// on the master stream, one transaction per pixel, tlast on the last pixel of
// each input item. The engine takes a new item every cycle while the output is
// not stalled; an item yielding more than one pixel keeps it busy, cutting one
// pixel per cycle out of its bit accumulator while the output accepts them. A
// four-entry command queue sits in front of the engine and a registered output
// stage behind it. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle (not enforced by the
// block); bit counts saturate to 8 and picture dimensions clamp to 1..2048 when written.
// ----------------------------------------------------------------------------
// text_to_pixel_bit_packer_unit
// Top level: configuration registers, input queue and pixel engine.
// ----------------------------------------------------------------------------
module text_to_pixel_bit_packer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] blue_value, [15:8] green_value, [23:16] red_value,
    // [34:24] pixel_column, [45:35] stored_row, [47:46] zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,   // last_of_run
    output logic [1:0]  m_axis_tuser    // [0] picture_complete, [1] overflow_error
);

    logic [tpbp_pkg::CHAN_W-1:0]  def_red_reg, def_green_reg, def_blue_reg;
    logic [tpbp_pkg::NBITS_W-1:0] red_bits_reg, green_bits_reg, blue_bits_reg;
    logic [tpbp_pkg::DIM_W-1:0]   width_reg, height_reg;
    tpbp_pkg::cfg_t               cfg;
    tpbp_pkg::queue_head_t        head;
    logic                         pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_red_reg    <= 8'd255;
            def_green_reg  <= 8'd0;
            def_blue_reg   <= 8'd0;
            red_bits_reg   <= 4'd0;
            green_bits_reg <= 4'd8;
            blue_bits_reg  <= 4'd8;
            width_reg      <= 12'd1;
            height_reg     <= 12'd1;
        end
        else if (cfg_we)
        begin
            case (tpbp_pkg::cfg_index_t'(cfg_index))
                tpbp_pkg::CFG_DEFAULT_RED:   def_red_reg   <= cfg_data[7:0];
                tpbp_pkg::CFG_DEFAULT_GREEN: def_green_reg <= cfg_data[7:0];
                tpbp_pkg::CFG_DEFAULT_BLUE:  def_blue_reg  <= cfg_data[7:0];
                tpbp_pkg::CFG_RED_BITS:
                    red_bits_reg <= tpbp_pkg::chan_sat(cfg_data[3:0]);
                tpbp_pkg::CFG_GREEN_BITS:
                    green_bits_reg <= tpbp_pkg::chan_sat(cfg_data[3:0]);
                tpbp_pkg::CFG_BLUE_BITS:
                    blue_bits_reg <= tpbp_pkg::chan_sat(cfg_data[3:0]);
                tpbp_pkg::CFG_WIDTH:
                    width_reg <= tpbp_pkg::clamp_dim(cfg_data,
                                     tpbp_pkg::DIM_W'(tpbp_pkg::MAX_WIDTH));
                tpbp_pkg::CFG_HEIGHT:
                    height_reg <= tpbp_pkg::clamp_dim(cfg_data,
                                      tpbp_pkg::DIM_W'(tpbp_pkg::MAX_HEIGHT));
                default:
                begin
                    def_red_reg <= def_red_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.default_red   = def_red_reg;
        cfg.default_green = def_green_reg;
        cfg.default_blue  = def_blue_reg;
        cfg.red_bits      = red_bits_reg;
        cfg.green_bits    = green_bits_reg;
        cfg.blue_bits     = blue_bits_reg;
        cfg.total_bits    = tpbp_pkg::PEND_W'(red_bits_reg)
                          + tpbp_pkg::PEND_W'(green_bits_reg)
                          + tpbp_pkg::PEND_W'(blue_bits_reg);
        cfg.width         = width_reg;
        cfg.height        = height_reg;
    end

    tpbp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .head          (head),
        .pop           (pop)
    );

    tpbp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
